>>> rtl/mexp_pkg.sv
// Shared constants and sequencer state type for the modular exponentiation block.
package mexp_pkg;

    localparam int OPERAND_BITS_DEF = 31;
    localparam int CFG_ADDR_BITS    = 2;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_MODULUS  = CFG_ADDR_BITS'(0);
    localparam logic [CFG_ADDR_BITS-1:0] CFG_EXPONENT = CFG_ADDR_BITS'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_REDUCE_WAIT,
        ST_CHECK,
        ST_MUL,
        ST_MUL_WAIT,
        ST_SQR,
        ST_SQR_WAIT
    } mexp_state_t;

endpackage

>>> rtl/mexp_modmul.sv
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle, MSB first.
module mexp_modmul #(
    parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [OPERAND_BITS-1:0] op_a,     // must be below the modulus
    input  logic [OPERAND_BITS-1:0] op_b,     // any value
    input  logic [OPERAND_BITS-1:0] modulus,  // nonzero, stable while busy
    output logic                    done,
    output logic [OPERAND_BITS-1:0] product
);
    import mexp_pkg::*;

    localparam int W     = OPERAND_BITS;
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     a_reg;
    logic [W-1:0]     b_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [W:0] dbl, red1, sum, red2, mod_ext;
    logic [W-1:0] addend;

    // acc = (2*acc + bit*a) mod m, each half needs one compare-subtract
    always_comb begin
        mod_ext  = {1'b0, modulus};
        dbl      = {acc_reg, 1'b0};
        red1     = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
        addend   = b_reg[W-1] ? a_reg : '0;
        sum      = {1'b0, red1[W-1:0]} + {1'b0, addend};
        red2     = (sum >= mod_ext) ? (sum - mod_ext) : sum;
        acc_next = red2[W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            a_reg   <= op_a;
            b_reg   <= op_b;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[W-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> rtl/modular_exponentiation.sv
// Top level: right-to-left square-and-multiply sequencer around a shared modular multiplier.
// Each multiplier pass (reduce, multiply or square) is followed by a check state. An item
// takes 1 + popcount(e) + floor(log2(e)) passes; exponent zero needs only the reduce pass.
// One item at a time; the next is taken while a finished result waits in the output register.
// aresetn is synchronous, active low: modulus returns to 1, exponent to 0, handshakes idle.
module modular_exponentiation #(
    parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wen,
    input  logic [mexp_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [OPERAND_BITS-1:0]            cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((OPERAND_BITS+7)/8)*8-1:0]  s_tdata,   // base_value
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [((OPERAND_BITS+7)/8)*8-1:0]  m_tdata    // power_result
);
    import mexp_pkg::*;

    localparam int W          = OPERAND_BITS;
    localparam int TDATA_BITS = ((OPERAND_BITS + 7) / 8) * 8;

    mexp_state_t state_reg, state_next;

    logic [W-1:0] modulus_reg, exponent_reg;
    logic [W-1:0] base_reg, exp_reg, sq_reg, acc_reg, out_reg;
    logic         m_valid_reg;

    logic [W-1:0] mod_eff, one_mod;
    logic         out_free, finish;
    logic         mul_start, mul_done;
    logic [W-1:0] mul_a, mul_b, mul_prod;

    // a zero modulus behaves as a modulus of one
    assign mod_eff  = (modulus_reg == '0) ? W'(1) : modulus_reg;
    assign one_mod  = (mod_eff == W'(1)) ? '0 : W'(1);
    assign out_free = !m_valid_reg || m_tready;
    assign finish   = (state_reg == ST_CHECK) && (exp_reg == '0) && out_free;

    mexp_modmul #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .modulus (mod_eff),
        .done    (mul_done),
        .product (mul_prod)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:        if (s_tvalid) state_next = ST_REDUCE;
            ST_REDUCE:      state_next = ST_REDUCE_WAIT;
            ST_REDUCE_WAIT: if (mul_done) state_next = ST_CHECK;
            ST_CHECK: begin
                if (exp_reg == '0) begin
                    if (out_free) state_next = ST_IDLE;
                end else if (exp_reg[0]) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_SQR;
                end
            end
            ST_MUL:         state_next = ST_MUL_WAIT;
            ST_MUL_WAIT:    if (mul_done) state_next = ST_CHECK;
            ST_SQR:         state_next = ST_SQR_WAIT;
            ST_SQR_WAIT:    if (mul_done) state_next = ST_CHECK;
            default:        state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        mul_start = 1'b0;
        mul_a     = sq_reg;
        mul_b     = sq_reg;
        case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_REDUCE: begin
                mul_start = 1'b1;
                mul_a     = one_mod;
                mul_b     = base_reg;
            end
            ST_MUL: begin
                mul_start = 1'b1;
                mul_b     = acc_reg;
            end
            ST_SQR:    mul_start = 1'b1;
            default:   mul_start = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            modulus_reg  <= W'(1);
            exponent_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wen) begin
                case (cfg_addr)
                    CFG_MODULUS:  modulus_reg  <= cfg_wdata;
                    CFG_EXPONENT: exponent_reg <= cfg_wdata;
                    default:      ;
                endcase
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                base_reg <= s_tdata[W-1:0];
                exp_reg  <= exponent_reg;
                acc_reg  <= W'(1);
            end
            ST_REDUCE_WAIT: if (mul_done) sq_reg <= mul_prod;
            ST_MUL_WAIT: begin
                if (mul_done) begin
                    acc_reg <= mul_prod;
                    exp_reg <= {exp_reg[W-1:1], 1'b0};
                end
            end
            ST_SQR_WAIT: begin
                if (mul_done) begin
                    sq_reg  <= mul_prod;
                    exp_reg <= {1'b0, exp_reg[W-1:1]};
                end
            end
            default: ;
        endcase
        if (finish) out_reg <= acc_reg;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_BITS'(out_reg);

endmodule

>>> rtl/mexp_checker.sv
// Port-level checker for the modular exponentiation block, with its bind.
module mexp_checker #(
    parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEF
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [((OPERAND_BITS+7)/8)*8-1:0] m_tdata
);
    import mexp_pkg::*;

    // reset empties the output register
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one item at a time: input closes right after a beat is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // no result can come out the cycle after an accept into an empty block
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

endmodule

bind modular_exponentiation mexp_checker #(
    .OPERAND_BITS(OPERAND_BITS)
) u_mexp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> verif/tb_modular_exponentiation.sv
// Testbench for modular_exponentiation: queued bases, stream driver and monitor, power predictor.
`timescale 1ns / 1ps

module tb_modular_exponentiation;
    import mexp_pkg::*;

    localparam int OB        = OPERAND_BITS_DEF;
    localparam int DW        = ((OB + 7) / 8) * 8;
    localparam int LATENCY   = (OB + 3) * 64;
    localparam int LONG_HOLD = 4000;
    localparam int ITEM_GOAL = 290;

    localparam logic [OB-1:0] OP_MAX = {OB{1'b1}};

    // indexes past the last register; writes there must not land anywhere
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE_LO = CFG_ADDR_BITS'(2);
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE_HI = CFG_ADDR_BITS'(3);

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     cfg_wen   = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
    logic [OB-1:0]            cfg_wdata = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [DW-1:0]            s_tdata   = '0;   // base_value
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [DW-1:0]            m_tdata;          // power_result

    // register copies kept in step with every write
    logic [OB-1:0] modulus_copy  = OB'(1);
    logic [OB-1:0] exponent_copy = '0;

    logic [OB-1:0] base_q[$];
    logic [OB-1:0] power_q[$];

    int  send_gap = 0;
    int  hold_cnt = 0;
    int  drv_roll, mon_roll;
    bit  idle_off      = 1'b0;
    bit  long_hold_req = 1'b0;

    int  n_queued = 0, n_checked = 0, n_fail = 0;
    int  n_settings = 0, n_zero_mod = 0, n_wide_exp = 0;

    modular_exponentiation dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // base^e mod m, scanning e from its low bit; zero modulus acts as one
    function automatic logic [OB-1:0] mod_power(input logic [OB-1:0] base,
                                                input logic [OB-1:0] e,
                                                input logic [OB-1:0] m);
        logic [63:0] n, sq, acc;
        n   = (m == '0) ? 64'd1 : 64'(m);
        sq  = 64'(base) % n;
        acc = 64'd1;
        for (int i = 0; i < OB; i++) begin
            if (e[i])
                acc = (acc * sq) % n;
            sq = (sq * sq) % n;
        end
        return acc[OB-1:0];
    endfunction

    // driver: hold a beat until taken, then maybe idle before the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                power_q.push_back(mod_power(s_tdata[OB-1:0], exponent_copy, modulus_copy));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (base_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= DW'(base_q.pop_front());
                    drv_roll = $urandom_range(99);
                    if (idle_off || drv_roll < 60)
                        send_gap = 0;
                    else if (drv_roll < 90)
                        send_gap = $urandom_range(1, 4);
                    else if (drv_roll < 97)
                        send_gap = $urandom_range(5, 40);
                    else
                        send_gap = $urandom_range(200, 2200);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result beat against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_cnt = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (power_q.size() == 0) begin
                    $display("%0t: power_result %0d arrived with none expected",
                             $time, m_tdata[OB-1:0]);
                    n_fail++;
                end else begin
                    n_checked++;
                    if (m_tdata[OB-1:0] !== power_q[0]) begin
                        $display("%0t: power_result expected %0d, got %0d",
                                 $time, power_q[0], m_tdata[OB-1:0]);
                        n_fail++;
                    end
                    void'(power_q.pop_front());
                end
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_cnt = LONG_HOLD;
            end
            mon_roll = $urandom_range(99);
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (!idle_off && mon_roll < 20) begin
                hold_cnt = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else if (!idle_off && mon_roll < 22) begin
                hold_cnt = $urandom_range(50, 400);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic reg_write(input logic [CFG_ADDR_BITS-1:0] idx, input logic [OB-1:0] val);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_MODULUS:  modulus_copy  = val;
            CFG_EXPONENT: exponent_copy = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic set_key(input logic [OB-1:0] m, input logic [OB-1:0] e);
        reg_write(CFG_MODULUS, m);
        reg_write(CFG_EXPONENT, e);
        n_settings++;
        if (m == '0)
            n_zero_mod++;
        if (e > OB'(16'hffff))
            n_wide_exp++;
    endtask

    task automatic queue_base(input logic [OB-1:0] b);
        base_q.push_back(b);
        n_queued++;
    endtask

    // sample on the falling edge so the driver's updates have all settled
    task automatic wait_drained;
        @(negedge aclk);
        while (base_q.size() != 0 || s_tvalid || power_q.size() != 0)
            @(negedge aclk);
    endtask

    initial begin
        logic [OB-1:0] m, e, b;
        int n, kind, phase;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values: modulus one, exponent zero
        queue_base('0);
        queue_base(OP_MAX);
        wait_drained();

        set_key(OP_MAX, OP_MAX);
        queue_base('0);
        queue_base(OB'(1));
        queue_base(OB'(2));
        queue_base(OP_MAX);
        queue_base(OP_MAX - 1'b1);
        wait_drained();

        // modulus one with a nonzero exponent collapses to zero
        set_key(OB'(1), OB'(5));
        queue_base(OP_MAX);
        queue_base(OB'(7));
        wait_drained();

        // zero modulus behaves as one
        set_key('0, OB'(3));
        queue_base(OB'(12345));
        queue_base(OP_MAX);
        wait_drained();
        reg_write(CFG_EXPONENT, '0);
        queue_base(OB'(99));
        wait_drained();

        // spare indexes leave both registers alone
        set_key(OB'(1000003), OB'(65537));
        reg_write(CFG_SPARE_LO, OB'($urandom()));
        reg_write(CFG_SPARE_HI, OB'($urandom()));
        queue_base(OB'(2));
        queue_base(OB'(1000003));
        queue_base(OB'(1000004));
        wait_drained();

        set_key(OP_MAX, OB'(1));
        queue_base(OP_MAX);
        queue_base(OP_MAX - 1'b1);
        wait_drained();

        set_key(OB'(2), OB'(2));
        queue_base(OB'(32'h5555_5555));
        queue_base(OB'(32'h2aaa_aaaa));
        wait_drained();

        set_key(OP_MAX, '0);
        queue_base(OB'(12345));
        wait_drained();

        phase = 0;
        while (n_queued < ITEM_GOAL) begin
            phase++;
            kind = $urandom_range(9);
            case (kind)
                0:       m = '0;
                1:       m = OP_MAX;
                2:       m = OB'($urandom_range(1, 255));
                3:       m = OB'(1) << $urandom_range(0, OB - 1);
                default: m = OB'($urandom());
            endcase
            kind = $urandom_range(9);
            case (kind)
                0:       e = '0;
                1:       e = OP_MAX;
                2:       e = OB'($urandom());
                3, 4:    e = OB'($urandom_range(0, 65535));
                default: e = OB'($urandom_range(1, 255));
            endcase
            n = $urandom_range(6, 20);
            // fill the block while the receiver holds off
            if (phase == 6) begin
                e = OB'($urandom_range(1, 15));
                n = 16;
                idle_off = 1'b1;
                long_hold_req = 1'b1;
            end
            if (phase == 3)
                idle_off = 1'b1;
            set_key(m, e);
            if (kind == 0)
                reg_write(CFG_SPARE_HI, OB'($urandom()));
            for (int k = 0; k < n; k++) begin
                kind = $urandom_range(9);
                case (kind)
                    0:       b = '0;
                    1:       b = OP_MAX;
                    2:       b = m * OB'($urandom_range(1, 7));
                    3:       b = m - 1'b1;
                    default: b = OB'($urandom());
                endcase
                queue_base(b);
            end
            wait_drained();
            idle_off = 1'b0;
        end

        repeat (LATENCY) @(posedge aclk);
        $display("%0d bases sent under %0d key settings",
                 n_queued, n_settings);
        $display("(%0d with zero modulus, %0d wide exponents), %0d results checked, %0d failures",
                 n_zero_mod, n_wide_exp, n_checked, n_fail);
        if (n_fail == 0 && power_q.size() == 0)
            $display("modular_exponentiation: match");
        else
            $display("modular_exponentiation: mismatch");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("timeout with %0d results outstanding", power_q.size());
        $display("modular_exponentiation: mismatch");
        $finish;
    end

endmodule
